/* sv/lsh_pkg.sv */
// Shared types and constants of the latency statistics histogram unit.
package lsh_pkg;

    localparam int NUM_TYPES_DEF = 16;
    localparam int NUM_BUCKETS   = 58;
    localparam int BKT_W         = 6;
    localparam int TYPE_IN_W     = 4;
    localparam int TIME_W        = 32;
    localparam int SUM_W         = 48;
    localparam int CNT_W         = 32;
    localparam int TIMEOUT_W     = 16;
    localparam int SLOW_FACTOR   = 750;
    localparam int TIMEOUT_RESET = 5000;
    localparam int LIMIT_W       = 26;
    localparam int THRESH_COUNT  = 55;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Bucket thresholds in microseconds, ascending.
    localparam logic [TIME_W-1:0] THRESH_US [THRESH_COUNT] = '{
        32'd1000, 32'd2000, 32'd3000, 32'd4000, 32'd5000, 32'd6000,
        32'd7000, 32'd8000, 32'd9000, 32'd10000, 32'd11000,
        32'd12000, 32'd14000, 32'd16000, 32'd18000, 32'd20000,
        32'd25000, 32'd30000, 32'd35000, 32'd40000, 32'd45000, 32'd50000,
        32'd60000, 32'd70000, 32'd80000, 32'd90000, 32'd100000,
        32'd120000, 32'd140000, 32'd160000, 32'd180000, 32'd200000,
        32'd250000, 32'd300000, 32'd350000, 32'd400000, 32'd450000, 32'd500000,
        32'd600000, 32'd700000, 32'd800000, 32'd900000, 32'd1000000,
        32'd2000000, 32'd3000000, 32'd4000000, 32'd5000000, 32'd7500000,
        32'd10000000,
        32'd20000000, 32'd30000000, 32'd40000000, 32'd50000000, 32'd75000000,
        32'd100000000
    };

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
        logic [TIME_W-1:0] min_us;
        logic [TIME_W-1:0] max_us;
    } stats_t;

    localparam stats_t STATS_EMPTY = '{count: '0, sum: '0, min_us: '1, max_us: '0};

endpackage

/* sv/latency_stats_histogram_unit.sv */
// Per-type latency statistics and semi-log histogram with read-modify-write memories.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   s_       | s_valid / s_ready    | kind, stat_type, time_us, bucket_select
//   m_       | m_valid / m_ready    | slow_call, bucket_index, count, sum, min,
//            |                      | max, bucket_count
//   cfg_     | cfg_valid / cfg_ready| timeout_ms write data
//
// One transfer per cycle while the output is accepted; the result passes through the input reg,
// the memory read and the output reg in that order.
// Same-entry back-to-back updates are forwarded.
// After reset a clearing pass walks all 2**(TYPE_W+6) bucket addresses (1024 at 16 types),
// zeroing the bucket counts and setting every type's statistics to empty; s_ready stays
// low during it. A stalled output holds the pipe behind it only once all stages are full.
module latency_stats_histogram_unit #(
    parameter int NUM_TYPES = lsh_pkg::NUM_TYPES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsh_pkg::TIMEOUT_W-1:0]    cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [lsh_pkg::TYPE_IN_W-1:0]    s_stat_type,
    input  logic [lsh_pkg::TIME_W-1:0]       s_time_us,
    input  logic [lsh_pkg::BKT_W-1:0]        s_bucket_select,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_slow_call,
    output logic [lsh_pkg::BKT_W-1:0]        m_bucket_index,
    output logic [lsh_pkg::CNT_W-1:0]        m_sample_count,
    output logic [lsh_pkg::SUM_W-1:0]        m_sample_sum,
    output logic [lsh_pkg::TIME_W-1:0]       m_min_time_us,
    output logic [lsh_pkg::TIME_W-1:0]       m_max_time_us,
    output logic [lsh_pkg::CNT_W-1:0]        m_bucket_count
);
    import lsh_pkg::*;

    localparam int TYPE_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int BADDR_W = TYPE_W + BKT_W;
    localparam int BDEPTH  = 1 << BADDR_W;
    localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(NUM_BUCKETS - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(TIMEOUT_RESET * SLOW_FACTOR);

    // memories
    logic [CNT_W-1:0] bkt_mem [BDEPTH];
    stats_t           stats_mem [NUM_TYPES];

    // config
    logic [LIMIT_W-1:0] limit_reg;

    // clearing pass
    logic               clr_busy_reg;
    logic [BADDR_W-1:0] clr_addr_reg;
    logic               clr_in_types;

    // stage 1
    logic                  s1_valid_reg;
    logic                  s1_kind_reg;
    logic [TYPE_IN_W-1:0]  s1_type_reg;
    logic [TIME_W-1:0]     s1_time_reg;
    logic [BKT_W-1:0]      s1_sel_reg;
    logic                  s1_go;
    logic                  s1_adv;
    logic                  s1_tvalid;
    logic [TYPE_W-1:0]     s1_tidx;
    logic [BKT_W-1:0]      s1_rec_bucket;
    logic [BKT_W-1:0]      s1_bucket;
    logic [BADDR_W-1:0]    s1_baddr;
    logic                  s1_slow;

    // stage 2
    logic                  s2_valid_reg;
    logic                  s2_kind_reg;
    logic                  s2_tvalid_reg;
    logic [TYPE_W-1:0]     s2_tidx_reg;
    logic [BADDR_W-1:0]    s2_baddr_reg;
    logic [BKT_W-1:0]      s2_bucket_reg;
    logic                  s2_slow_reg;
    logic [TIME_W-1:0]     s2_time_reg;
    logic                  s2_thit_reg;
    logic                  s2_bhit_reg;
    logic                  s2_thit_next;
    logic                  s2_bhit_next;
    logic [CNT_W-1:0]      bkt_rd_reg;
    stats_t                stats_rd_reg;
    logic [CNT_W-1:0]      fwd_cnt_reg;
    stats_t                fwd_stats_reg;
    logic                  s2_go;
    logic                  s2_upd;
    logic                  wr_en;
    stats_t                cur_stats;
    stats_t                new_stats;
    stats_t                res_stats;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      new_cnt;
    logic [CNT_W-1:0]      res_cnt;
    logic [SUM_W:0]        sum_wide;

    // output
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  m_slow_reg;
    logic [BKT_W-1:0]      m_bucket_reg;
    stats_t                m_stats_reg;
    logic [CNT_W-1:0]      m_cnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= LIMIT_W'(cfg_data) * LIMIT_W'(SLOW_FACTOR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clr_in_types = int'(clr_addr_reg) < NUM_TYPES;

    // handshake
    assign s2_go   = !m_valid_reg || m_ready;
    assign s1_go   = !s2_valid_reg || s2_go;
    assign s1_adv  = s1_valid_reg && s1_go;
    assign s2_upd  = s2_valid_reg && s2_go;
    assign s_ready = !clr_busy_reg && (!s1_valid_reg || s1_go);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_kind_reg <= s_kind;
            s1_type_reg <= s_stat_type;
            s1_time_reg <= s_time_us;
            s1_sel_reg  <= s_bucket_select;
        end
    end

    // bucket = number of thresholds at or below the duration
    always_comb begin
        logic lo;
        logic hi;
        s1_rec_bucket = '0;
        for (int n = 0; n <= THRESH_COUNT; n++) begin
            lo = (n == 0) ? 1'b1 : (s1_time_reg >= THRESH_US[(n == 0) ? 0 : n - 1]);
            hi = (n == THRESH_COUNT) ? 1'b0
                 : (s1_time_reg >= THRESH_US[(n == THRESH_COUNT) ? 0 : n]);
            if (lo && !hi) begin
                s1_rec_bucket = s1_rec_bucket | BKT_W'(n);
            end
        end
    end

    assign s1_tvalid = int'(s1_type_reg) < NUM_TYPES;
    assign s1_tidx   = TYPE_W'(s1_type_reg);
    assign s1_bucket = (s1_kind_reg == KIND_RECORD) ? s1_rec_bucket
                     : ((s1_sel_reg > BKT_LAST) ? BKT_LAST : s1_sel_reg);
    assign s1_baddr  = {s1_tidx, s1_bucket};
    assign s1_slow   = (s1_kind_reg == KIND_RECORD) && (s1_time_reg >= TIME_W'(limit_reg));

    // forward when the entry read now is the one written at the same edge
    assign s2_thit_next = s2_upd && (s2_kind_reg == KIND_RECORD) && s2_tvalid_reg
                        && (s2_tidx_reg == s1_tidx);
    assign s2_bhit_next = s2_upd && (s2_kind_reg == KIND_RECORD) && s2_tvalid_reg
                        && (s2_baddr_reg == s1_baddr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_kind_reg   <= s1_kind_reg;
            s2_tvalid_reg <= s1_tvalid;
            s2_tidx_reg   <= s1_tidx;
            s2_baddr_reg  <= s1_baddr;
            s2_bucket_reg <= s1_bucket;
            s2_slow_reg   <= s1_slow;
            s2_time_reg   <= s1_time_reg;
            s2_thit_reg   <= s2_thit_next;
            s2_bhit_reg   <= s2_bhit_next;
        end
    end

    // memory reads
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            bkt_rd_reg   <= bkt_mem[s1_baddr];
            stats_rd_reg <= stats_mem[s1_tidx];
        end
    end

    // modify
    assign cur_stats = s2_thit_reg ? fwd_stats_reg : stats_rd_reg;
    assign cur_cnt   = s2_bhit_reg ? fwd_cnt_reg : bkt_rd_reg;
    assign sum_wide  = {1'b0, cur_stats.sum} + (SUM_W + 1)'(s2_time_reg);

    always_comb begin
        new_stats.count  = (&cur_stats.count) ? cur_stats.count : cur_stats.count + 1'b1;
        new_stats.sum    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        new_stats.min_us = (s2_time_reg < cur_stats.min_us) ? s2_time_reg : cur_stats.min_us;
        new_stats.max_us = (s2_time_reg > cur_stats.max_us) ? s2_time_reg : cur_stats.max_us;
        new_cnt          = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
    end

    always_comb begin
        if (!s2_tvalid_reg) begin
            res_stats = STATS_EMPTY;
            res_cnt   = '0;
        end else if (s2_kind_reg == KIND_RECORD) begin
            res_stats = new_stats;
            res_cnt   = new_cnt;
        end else begin
            res_stats = cur_stats;
            res_cnt   = cur_cnt;
        end
    end

    assign wr_en = s2_upd && (s2_kind_reg == KIND_RECORD) && s2_tvalid_reg;

    // memory writes
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            bkt_mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            bkt_mem[s2_baddr_reg] <= new_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            if (clr_in_types) begin
                stats_mem[clr_addr_reg[TYPE_W-1:0]] <= STATS_EMPTY;
            end
        end else if (wr_en) begin
            stats_mem[s2_tidx_reg] <= new_stats;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_cnt_reg   <= new_cnt;
            fwd_stats_reg <= new_stats;
        end
    end

    // output register
    always_comb begin
        if (s2_upd) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_upd) begin
            m_slow_reg   <= s2_slow_reg;
            m_bucket_reg <= s2_bucket_reg;
            m_stats_reg  <= res_stats;
            m_cnt_reg    <= res_cnt;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slow_call    = m_slow_reg;
    assign m_bucket_index = m_bucket_reg;
    assign m_sample_count = m_stats_reg.count;
    assign m_sample_sum   = m_stats_reg.sum;
    assign m_min_time_us  = m_stats_reg.min_us;
    assign m_max_time_us  = m_stats_reg.max_us;
    assign m_bucket_count = m_cnt_reg;

endmodule

/* sim/lsh_stats_checker.sv */
`timescale 1ns / 1ps
// Result checker for the latency statistics histogram unit: mirrors its statistics and compares.
module lsh_stats_checker #(
    parameter int NUM_TYPES = lsh_pkg::NUM_TYPES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lsh_pkg::TIMEOUT_W-1:0] cfg_data,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_kind,
    input  logic [lsh_pkg::TYPE_IN_W-1:0] s_stat_type,
    input  logic [lsh_pkg::TIME_W-1:0]    s_time_us,
    input  logic [lsh_pkg::BKT_W-1:0]     s_bucket_select,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_slow_call,
    input  logic [lsh_pkg::BKT_W-1:0]     m_bucket_index,
    input  logic [lsh_pkg::CNT_W-1:0]     m_sample_count,
    input  logic [lsh_pkg::SUM_W-1:0]     m_sample_sum,
    input  logic [lsh_pkg::TIME_W-1:0]    m_min_time_us,
    input  logic [lsh_pkg::TIME_W-1:0]    m_max_time_us,
    input  logic [lsh_pkg::CNT_W-1:0]     m_bucket_count,

    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            slow_count
);

    localparam int          BUCKETS     = lsh_pkg::NUM_BUCKETS;
    localparam int unsigned US_PER_MS   = 1000;
    localparam int unsigned SLOW_SCALE  = 750;
    localparam logic [15:0] TIMEOUT_RST = 16'd5000;

    // Semi-log bucket edges in milliseconds.
    localparam int unsigned EDGES_MS [55] = '{
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11,
        12, 14, 16, 18, 20,
        25, 30, 35, 40, 45, 50,
        60, 70, 80, 90, 100,
        120, 140, 160, 180, 200,
        250, 300, 350, 400, 450, 500,
        600, 700, 800, 900, 1000,
        2000, 3000, 4000, 5000, 7500, 10000,
        20000, 30000, 40000, 50000, 75000, 100000
    };

    typedef struct {
        logic        slow;
        logic [5:0]  bucket;
        logic [31:0] count;
        logic [47:0] sum;
        logic [31:0] min_us;
        logic [31:0] max_us;
        logic [31:0] bcount;
    } stats_result_t;

    logic [15:0]   timeout_ms;
    logic [31:0]   n_samples [NUM_TYPES];
    logic [47:0]   total_us  [NUM_TYPES];
    logic [31:0]   fastest   [NUM_TYPES];
    logic [31:0]   slowest   [NUM_TYPES];
    logic [31:0]   hist      [NUM_TYPES][BUCKETS];
    stats_result_t awaited_stats [$];

    function automatic logic [5:0] bucket_of_ms(input logic [31:0] ms);
        int n;
        n = 0;
        foreach (EDGES_MS[i]) begin
            if (EDGES_MS[i] <= ms)
                n++;
        end
        return 6'(n);
    endfunction

    function automatic stats_result_t predict_stats(input logic kind, input logic [3:0] st,
                                                    input logic [31:0] tus,
                                                    input logic [5:0] sel);
        stats_result_t r;
        logic [48:0]   acc;
        int            t;
        t = st;
        r.slow = 1'b0;
        r.bcount = '0;
        if (kind == lsh_pkg::KIND_RECORD) begin
            r.slow = (64'(tus) >= 64'(timeout_ms) * SLOW_SCALE);
            r.bucket = bucket_of_ms(tus / US_PER_MS);
            if (t < NUM_TYPES) begin
                if (hist[t][r.bucket] != '1)
                    hist[t][r.bucket]++;
                r.bcount = hist[t][r.bucket];
                if (n_samples[t] != '1)
                    n_samples[t]++;
                acc = 49'(total_us[t]) + 49'(tus);
                total_us[t] = acc[48] ? '1 : acc[47:0];
                if (tus < fastest[t])
                    fastest[t] = tus;
                if (tus > slowest[t])
                    slowest[t] = tus;
            end
        end else begin
            r.bucket = (sel > BUCKETS - 1) ? 6'(BUCKETS - 1) : sel;
            if (t < NUM_TYPES)
                r.bcount = hist[t][r.bucket];
        end
        if (t < NUM_TYPES) begin
            r.count = n_samples[t];
            r.sum = total_us[t];
            r.min_us = fastest[t];
            r.max_us = slowest[t];
        end else begin
            r.count = '0;
            r.sum = '0;
            r.min_us = '1;
            r.max_us = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
        if (got !== want) begin
            if (fail_count < 10)
                $display("[%0t] result %0d: %s expected %0h, got %0h",
                         $realtime, result_count, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        stats_result_t want;
        if (!aresetn) begin
            timeout_ms = TIMEOUT_RST;
            for (int t = 0; t < NUM_TYPES; t++) begin
                n_samples[t] = '0;
                total_us[t] = '0;
                fastest[t] = '1;
                slowest[t] = '0;
                for (int b = 0; b < BUCKETS; b++)
                    hist[t][b] = '0;
            end
            awaited_stats.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                timeout_ms = cfg_data;
            if (s_valid && s_ready)
                awaited_stats.push_back(predict_stats(s_kind, s_stat_type, s_time_us,
                                                      s_bucket_select));
            if (m_valid && m_ready) begin
                result_count++;
                if (m_slow_call === 1'b1)
                    slow_count++;
                if (awaited_stats.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] result %0d: transfer with nothing outstanding",
                                 $realtime, result_count);
                    fail_count++;
                end else begin
                    want = awaited_stats.pop_front();
                    check_field("slow_call", 48'(want.slow), 48'(m_slow_call));
                    check_field("bucket_index", 48'(want.bucket), 48'(m_bucket_index));
                    check_field("sample_count", 48'(want.count), 48'(m_sample_count));
                    check_field("sample_sum", want.sum, m_sample_sum);
                    check_field("min_time_us", 48'(want.min_us), 48'(m_min_time_us));
                    check_field("max_time_us", 48'(want.max_us), 48'(m_max_time_us));
                    check_field("bucket_count", 48'(want.bcount), 48'(m_bucket_count));
                end
            end
        end
        pending = awaited_stats.size();
    end

endmodule

/* sim/tb_latency_stats_histogram_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the latency statistics histogram unit: stimulus, flow control and verdict.
module tb_latency_stats_histogram_unit;

    localparam int NUM_TYPES       = lsh_pkg::NUM_TYPES_DEF;
    localparam int ITEMS_PER_PHASE = 258;
    localparam int CYCLE_LIMIT     = 400000;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [lsh_pkg::TIMEOUT_W-1:0] cfg_data        = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic                          s_kind          = lsh_pkg::KIND_RECORD;
    logic [lsh_pkg::TYPE_IN_W-1:0] s_stat_type     = '0;
    logic [lsh_pkg::TIME_W-1:0]    s_time_us       = '0;
    logic [lsh_pkg::BKT_W-1:0]     s_bucket_select = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b1;
    logic                          m_slow_call;
    logic [lsh_pkg::BKT_W-1:0]     m_bucket_index;
    logic [lsh_pkg::CNT_W-1:0]     m_sample_count;
    logic [lsh_pkg::SUM_W-1:0]     m_sample_sum;
    logic [lsh_pkg::TIME_W-1:0]    m_min_time_us;
    logic [lsh_pkg::TIME_W-1:0]    m_max_time_us;
    logic [lsh_pkg::CNT_W-1:0]     m_bucket_count;

    int          fail_count;
    int          pending;
    int          result_count;
    int          slow_count;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    int          n_records;
    int          n_reads;
    int          cycles;
    int unsigned cur_timeout = lsh_pkg::TIMEOUT_RESET;
    int unsigned timeouts [6];
    logic [3:0]  last_type;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    latency_stats_histogram_unit #(
        .NUM_TYPES(NUM_TYPES)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_stat_type    (s_stat_type),
        .s_time_us      (s_time_us),
        .s_bucket_select(s_bucket_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slow_call    (m_slow_call),
        .m_bucket_index (m_bucket_index),
        .m_sample_count (m_sample_count),
        .m_sample_sum   (m_sample_sum),
        .m_min_time_us  (m_min_time_us),
        .m_max_time_us  (m_max_time_us),
        .m_bucket_count (m_bucket_count)
    );

    lsh_stats_checker #(
        .NUM_TYPES(NUM_TYPES)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_stat_type    (s_stat_type),
        .s_time_us      (s_time_us),
        .s_bucket_select(s_bucket_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slow_call    (m_slow_call),
        .m_bucket_index (m_bucket_index),
        .m_sample_count (m_sample_count),
        .m_sample_sum   (m_sample_sum),
        .m_min_time_us  (m_min_time_us),
        .m_max_time_us  (m_max_time_us),
        .m_bucket_count (m_bucket_count),
        .fail_count     (fail_count),
        .pending        (pending),
        .result_count   (result_count),
        .slow_count     (slow_count)
    );

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called and returns on a falling edge.
    task automatic send_item(input logic kind, input logic [3:0] st, input logic [31:0] tus,
                             input logic [5:0] sel);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_kind = kind;
        s_stat_type = st;
        s_time_us = tus;
        s_bucket_select = sel;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (kind == lsh_pkg::KIND_RECORD)
            n_records++;
        else
            n_reads++;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge aclk);
    endtask

    // Durations biased toward bucket edges and the slow-call limit.
    function automatic logic [31:0] pick_time_us();
        int unsigned choice;
        logic [31:0] thr_us;
        choice = $urandom_range(0, 9);
        case (choice)
            0, 1, 2, 3: begin
                thr_us = lsh_pkg::THRESH_US[$urandom_range(0, lsh_pkg::THRESH_COUNT - 1)];
                case ($urandom_range(0, 4))
                    0:       return thr_us - 1;
                    1:       return thr_us;
                    2:       return thr_us + 999;
                    3:       return thr_us + 1000;
                    default: return thr_us + $urandom_range(0, 999);
                endcase
            end
            4: begin
                thr_us = cur_timeout * lsh_pkg::SLOW_FACTOR;
                return thr_us + $urandom_range(0, 2) - 1;
            end
            5:       return $urandom_range(0, 2000);
            6:       return $urandom_range(0, 200_000_000);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        timeouts = '{0, 65535, 1, 0, 40, lsh_pkg::TIMEOUT_RESET};
        timeouts[3] = $urandom_range(2, 65534);
        last_type = '0;

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty reads, bucket edges, slow limit, field extremes, same-bucket bursts
        send_item(lsh_pkg::KIND_READ,   4'd0,  32'd0,          6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd0,  32'd0,          6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd0,  32'd999,        6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd0,  32'd1000,       6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd0,  32'h5555_5555,  6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd0,  32'hAAAA_AAAA,  6'd63);
        send_item(lsh_pkg::KIND_RECORD, 4'd15, 32'hFFFF_FFFF,  6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd15, 32'd100_000_000, 6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd15, 32'd99_999_999, 6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd3,  32'd3_749_999,  6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd3,  32'd3_750_000,  6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd3,  32'd11_999,     6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd3,  32'd12_000,     6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd5,  32'd2500,       6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd5,  32'd2500,       6'd0);
        send_item(lsh_pkg::KIND_RECORD, 4'd5,  32'd2500,       6'd0);
        send_item(lsh_pkg::KIND_READ,   4'd5,  32'd0,          6'd2);
        send_item(lsh_pkg::KIND_READ,   4'd15, 32'd0,          6'd55);
        send_item(lsh_pkg::KIND_READ,   4'd3,  32'd0,          6'd56);
        send_item(lsh_pkg::KIND_READ,   4'd3,  32'd0,          6'd57);
        send_item(lsh_pkg::KIND_READ,   4'd3,  32'd0,          6'd58);
        send_item(lsh_pkg::KIND_READ,   4'd3,  32'hFFFF_FFFF,  6'd63);
        send_item(lsh_pkg::KIND_READ,   4'd7,  32'd0,          6'h2A);
        send_item(lsh_pkg::KIND_READ,   4'd0,  32'd0,          6'h15);
        send_item(lsh_pkg::KIND_READ,   4'd10, 32'd0,          6'd1);
        s_valid = 1'b0;
        wait_drained();
        repeat (4) @(negedge aclk);

        foreach (timeouts[p]) begin
            cfg_valid = 1'b1;
            cfg_data = timeouts[p][15:0];
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
            cfg_valid = 1'b0;
            cur_timeout = timeouts[p];

            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 57; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 57; end
                default: begin snd_idle_pct = 38; rcv_stall_pct = 38; end
            endcase

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) begin
                    s_valid = 1'b0;
                    wait_drained();
                end
                if ($urandom_range(0, 99) >= 40)
                    last_type = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 99) < 65)
                    send_item(lsh_pkg::KIND_RECORD, last_type, pick_time_us(),
                              6'($urandom_range(0, 63)));
                else
                    send_item(lsh_pkg::KIND_READ, last_type, $urandom(),
                              ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 55))
                                                           : 6'($urandom_range(0, 63)));
            end
            s_valid = 1'b0;
            wait_drained();
            repeat (4) @(negedge aclk);
        end

        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        wait_drained();
        repeat (10) @(negedge aclk);

        $display("Summary: %0d record and %0d read transfers, %0d timeout settings plus reset value",
                 n_records, n_reads, $size(timeouts));
        $display("Summary: %0d results compared, %0d flagged as slow calls",
                 result_count, slow_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
